// ===== rtl/sstc_pkg.sv =====
// Shared constants and helpers for the sum-of-two-squares counter.
`default_nettype none
package sstc_pkg;
  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int COUNT_W    = 14;
  localparam int DIV_W      = VALUE_BITS / 2 + 2;
  localparam int SQ_W       = VALUE_BITS + 2;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int BAL_W      = 16;
  localparam int WT_W       = 3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [1:0] RES_ONE   = 2'd1;
  localparam logic [1:0] RES_THREE = 2'd3;

  // +1 for 1 mod 4, -1 for 3 mod 4, 0 for even
  function automatic logic signed [WT_W-1:0] residue_weight(input logic [1:0] r);
    logic signed [WT_W-1:0] w;
    w = '0;
    if (r == RES_ONE) w = WT_W'(1);
    else if (r == RES_THREE) w = -WT_W'(1);
    return w;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/sstc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module sstc_div import sstc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [DIV_W-1:0]      divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic [DIV_W-1:0]           remainder
);
  logic                  active;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] qr;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      dsr;
  logic [DIV_W:0]        rem_sh;
  logic                  fit;
  logic [DIV_W-1:0]      rem_next;

  always_comb begin
    rem_sh   = {rem, qr[VALUE_BITS-1]};
    fit      = rem_sh >= {1'b0, dsr};
    rem_next = fit ? DIV_W'(rem_sh - {1'b0, dsr}) : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(VALUE_BITS - 1);
        qr     <= dividend;
        rem    <= '0;
        dsr    <= divisor;
      end else if (active) begin
        rem <= rem_next;
        qr  <= {qr[VALUE_BITS-2:0], fit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = qr;
  assign remainder = rem;
endmodule
`default_nettype wire

// ===== rtl/sum_of_two_squares_count_core.sv =====
// Top level of the sum-of-two-squares counter r2(n).
// Pulse start while busy is low to take value_n; busy stays high until the
// result beat, when done is high for one cycle with rep_count, which must be
// captured then as it cannot be held off. Trial divisors d run from 1 while
// d*d <= n, each tested in turn by the bit-serial divider from S_CHECK and
// S_WAIT; n = 0 gives its result in the cycle after it is taken.
`default_nettype none
module sum_of_two_squares_count_core import sstc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [IN_W-1:0]    value_n,
  output logic                    busy,
  output logic                    done,
  output logic [COUNT_W-1:0]      rep_count
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]              state;
  logic [VALUE_BITS-1:0]   n;
  logic [DIV_W-1:0]        d;
  logic [SQ_W-1:0]         sq;
  logic signed [BAL_W-1:0] balance;
  logic                    past_root;
  logic                    div_start;
  logic                    div_done;
  logic [VALUE_BITS-1:0]   quo;
  logic [DIV_W-1:0]        rem;
  logic signed [WT_W-1:0]  w_d;
  logic signed [WT_W-1:0]  w_q;
  logic signed [BAL_W-1:0] balance_next;
  logic [COUNT_W-1:0]      count_final;

  sstc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    past_root = sq > SQ_W'(n);
    div_start = (state == S_CHECK) && !past_root;
    w_d = residue_weight(d[1:0]);
    w_q = (quo != VALUE_BITS'(d)) ? residue_weight(quo[1:0]) : '0;
    balance_next = balance;
    if (rem == '0) begin
      balance_next = balance + BAL_W'(w_d) + BAL_W'(w_q);
    end
    if (balance <= 0) begin
      count_final = '0;
    end else if (balance > BAL_W'(COUNT_MAX >> 2)) begin
      count_final = COUNT_MAX;
    end else begin
      count_final = {balance[COUNT_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n       <= VALUE_BITS'(value_n);
            d       <= DIV_W'(1);
            sq      <= SQ_W'(1);
            balance <= '0;
            if (VALUE_BITS'(value_n) == '0) begin
              rep_count <= COUNT_W'(1);
              done      <= 1'b1;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (past_root) begin
            rep_count <= count_final;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            balance <= balance_next;
            sq      <= sq + SQ_W'({d, 1'b1});
            d       <= d + DIV_W'(1);
            state   <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;
endmodule
`default_nettype wire
